// ===== rtl/core/dps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and sizes of the dynamic priority scheduler.
package dps_pkg;

  localparam int DPS_MAX_PROCS   = 16;
  localparam int DPS_QUEUE_DEPTH = 2;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] ST_RAN      = 3'd0;
  localparam logic [2:0] ST_FINISHED = 3'd1;
  localparam logic [2:0] ST_IDLE     = 3'd2;
  localparam logic [2:0] ST_ADDED    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic signed [7:0] DPS_PRIO_MIN = 8'sh80;
  localparam logic [9:0]        DPS_TIME_STEP_LIMIT = 10'd10;
  localparam logic [17:0]       DPS_RECIP_TEN = 18'd205;

  typedef struct packed {
    logic       func;
    logic [7:0] proc_id;
    logic [3:0] start_priority;
    logic [9:0] time_need;
  } dps_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        ran_id;
    logic [9:0]        time_left;
    logic signed [7:0] priority_now;
    logic [7:0]        next_id;
    logic              next_valid;
  } dps_out_t;

  typedef struct packed {
    logic       op;
    logic [7:0] proc_id;
    logic [3:0] start_priority;
    logic [9:0] time_need;
  } dps_cmd_t;

  typedef struct packed {
    logic [7:0]        id;
    logic signed [7:0] prio;
    logic [9:0]        time_left;
  } dps_entry_t;

endpackage

// ===== rtl/core/dps_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words and decodes them into scheduler commands.
module dps_front import dps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dps_in_t  in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output dps_cmd_t cmd
);

  logic     hold_valid_r;
  dps_cmd_t cmd_r;
  dps_cmd_t cmd_nxt;

  assign in_ready  = !hold_valid_r || cmd_ready;
  assign cmd_valid = hold_valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    cmd_nxt.op             = in_data.func ? OP_TICK : OP_ADD;
    cmd_nxt.proc_id        = in_data.proc_id;
    cmd_nxt.start_priority = in_data.start_priority;
    cmd_nxt.time_need      = in_data.time_need;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== rtl/core/dps_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the execution engine.
module dps_fifo import dps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  dps_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output dps_cmd_t pop_data
);

  localparam int DEPTH = DPS_QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  dps_cmd_t        slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   fill_r, fill_nxt;
  logic            do_push, do_pop;

  assign push_ready = (fill_r != NW'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + NW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/dps_back.sv =====
`timescale 1ns / 1ps
// Execution engine: process table memory, tick update, search, compaction.
module dps_back import dps_pkg::*; #(
  parameter int MAX_PROCS = DPS_MAX_PROCS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  dps_cmd_t cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output dps_out_t out_data
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD      = 4'd1;
  localparam logic [3:0] S_TICK_RD  = 4'd2;
  localparam logic [3:0] S_TICK_EXE = 4'd3;
  localparam logic [3:0] S_HEAD     = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CMP = 4'd6;
  localparam logic [3:0] S_SH_RD    = 4'd7;
  localparam logic [3:0] S_SH_WR    = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;
  localparam logic [3:0] S_FIN2     = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  dps_entry_t mem [MAX_PROCS];

  logic [3:0]        state_r, state_nxt;
  dps_cmd_t          cmd_r, cmd_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     best_r, best_nxt;
  logic signed [7:0] best_p_r, best_p_nxt;
  dps_out_t          res_r, res_nxt;
  dps_entry_t        rd_r;
  logic              out_valid_r;
  dps_out_t          out_data_r;

  logic              we, re;
  logic [IW-1:0]     waddr, raddr;
  dps_entry_t        wdata;

  logic [9:0]        t_cur, t_new;
  logic signed [7:0] p_cur, p_new, p_rd, p_res, head_p;
  logic [17:0]       t_prod;
  logic [CW-1:0]     idx_inc;
  logic              out_free;

  assign t_cur   = rd_r.time_left;
  assign p_cur   = rd_r.prio;
  assign p_rd    = rd_r.prio;
  assign p_res   = res_r.priority_now;
  assign t_prod  = {8'd0, t_cur} * DPS_RECIP_TEN;
  assign t_new   = (t_cur == 10'd0) ? t_cur :
                   (t_cur > DPS_TIME_STEP_LIMIT) ? t_cur - {3'd0, t_prod[17:11]} :
                   t_cur - 10'd1;
  assign p_new   = (t_cur == 10'd0 || p_cur == DPS_PRIO_MIN) ? p_cur : p_cur - 8'sd1;
  assign head_p  = (cur_r == '0) ? p_res : p_rd;
  assign idx_inc = idx_r + CW'(1);
  assign out_free = !out_valid_r || out_ready;

  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    best_nxt   = best_r;
    best_p_nxt = best_p_r;
    res_nxt    = res_r;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = cur_r;
    raddr      = cur_r;
    wdata      = rd_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd;
          res_nxt = '0;
          if (cmd.op == OP_ADD) begin
            state_nxt = S_ADD;
          end else if (count_r == '0) begin
            res_nxt.status = ST_IDLE;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_TICK_RD;
          end
        end
      end
      S_ADD: begin
        if (count_r == CW'(MAX_PROCS)) begin
          res_nxt.status = ST_FULL;
        end else begin
          we              = 1'b1;
          waddr           = count_r[IW-1:0];
          wdata.id        = cmd_r.proc_id;
          wdata.prio      = $signed({4'd0, cmd_r.start_priority});
          wdata.time_left = cmd_r.time_need;
          count_nxt       = count_r + CW'(1);
          res_nxt.status  = ST_ADDED;
        end
        state_nxt = S_FIN;
      end
      S_TICK_RD: begin
        re        = 1'b1;
        raddr     = cur_r;
        state_nxt = S_TICK_EXE;
      end
      S_TICK_EXE: begin
        res_nxt.ran_id       = rd_r.id;
        res_nxt.time_left    = t_new;
        res_nxt.priority_now = p_new;
        if (t_cur != 10'd0) begin
          we              = 1'b1;
          waddr           = cur_r;
          wdata.id        = rd_r.id;
          wdata.prio      = p_new;
          wdata.time_left = t_new;
        end
        if (t_new == 10'd0) begin
          res_nxt.status = ST_FINISHED;
          idx_nxt        = CW'(cur_r);
          state_nxt      = S_SH_RD;
        end else begin
          res_nxt.status = ST_RAN;
          re             = 1'b1;
          raddr          = '0;
          state_nxt      = S_HEAD;
        end
      end
      S_HEAD: begin
        if (p_res <= head_p) begin
          best_nxt   = '0;
          best_p_nxt = head_p;
          idx_nxt    = CW'(1);
          state_nxt  = S_SCAN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN_RD: begin
        if (idx_r >= count_r) begin
          cur_nxt   = best_r;
          state_nxt = S_FIN;
        end else begin
          re        = 1'b1;
          raddr     = idx_r[IW-1:0];
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (p_rd > best_p_r) begin
          best_nxt   = idx_r[IW-1:0];
          best_p_nxt = p_rd;
        end
        idx_nxt   = idx_inc;
        state_nxt = S_SCAN_RD;
      end
      S_SH_RD: begin
        if (idx_inc >= count_r) begin
          count_nxt = count_r - CW'(1);
          cur_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          re        = 1'b1;
          raddr     = idx_inc[IW-1:0];
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        we        = 1'b1;
        waddr     = idx_r[IW-1:0];
        wdata     = rd_r;
        idx_nxt   = idx_inc;
        state_nxt = S_SH_RD;
      end
      S_FIN: begin
        re        = 1'b1;
        raddr     = cur_r;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        if (count_r != '0) begin
          res_nxt.next_id    = rd_r.id;
          res_nxt.next_valid = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cur_r   <= cur_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    best_r   <= best_nxt;
    best_p_r <= best_p_nxt;
    res_r    <= res_nxt;
    if (state_r == S_OUT && out_free) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/dynamic_priority_scheduler_top.sv =====
`timescale 1ns / 1ps
// Top level of the dynamic priority scheduler: front end, queue, engine.
//
//   Channel | Ports                      | Word
//   input   | in_valid, in_ready, in_data  | dps_in_t  (add or tick)
//   result  | out_valid, out_ready, out_data | dps_out_t (one per input)
//
// Add writes one entry; an empty tick reports idle. A tick updates the
// current entry, then shifts the entries behind it forward if it finished,
// else scans the entries after the head for the highest priority.
// Reset (rst_n low, synchronous) empties the table and the queue.
// The front end and a 2-word queue keep taking words while the engine
// works or the result register waits on out_ready.
module dynamic_priority_scheduler_top import dps_pkg::*; #(
  parameter int MAX_PROCS = DPS_MAX_PROCS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dps_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dps_out_t out_data
);

  logic     f_valid, f_ready;
  dps_cmd_t f_cmd;
  logic     q_valid, q_ready;
  dps_cmd_t q_cmd;

  dps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  dps_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  dps_back #(
    .MAX_PROCS (MAX_PROCS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_IDLE |->
      !out_data.next_valid && out_data.ran_id == 8'd0)
    else $error("idle result reports a process");

  a_added_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_ADDED || out_data.status == ST_RAN ||
                  out_data.status == ST_FULL) |-> out_data.next_valid)
    else $error("table reported empty while a process remains");

  a_ran_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_RAN |-> out_data.time_left != 10'd0)
    else $error("process with no time left was kept");

  a_fin_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FINISHED |-> out_data.time_left == 10'd0)
    else $error("process removed with time left");

endmodule

// ===== bench/dynamic_priority_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the scheduler: tracks the process table and compares every report.
module dynamic_priority_scheduler_top_tb;
  import dps_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_WORDS = 400;

  class sched_table_check;
    logic [7:0]        ids[DPS_MAX_PROCS];
    logic signed [7:0] prios[DPS_MAX_PROCS];
    logic [9:0]        times[DPS_MAX_PROCS];
    int unsigned count = 0;
    int unsigned cur = 0;
    int unsigned errors = 0;
    int unsigned n_add = 0;
    int unsigned n_full = 0;
    int unsigned n_tick = 0;
    int unsigned n_done = 0;
    int unsigned n_empty = 0;
    dps_out_t pending_reports[$];

    function void note_word(dps_in_t w);
      dps_out_t r;
      logic [9:0] t;
      logic signed [7:0] p;
      int unsigned best;
      r = '0;
      if (w.func == OP_ADD) begin
        n_add++;
        if (count >= DPS_MAX_PROCS) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          ids[count] = w.proc_id;
          prios[count] = {4'b0000, w.start_priority};
          times[count] = w.time_need;
          count++;
          r.status = ST_ADDED;
        end
      end else if (count == 0) begin
        n_tick++;
        n_empty++;
        r.status = ST_IDLE;
      end else begin
        n_tick++;
        if (cur >= count) cur = 0;
        t = times[cur];
        p = prios[cur];
        if (t != 0) begin
          t = (t > DPS_TIME_STEP_LIMIT) ? t - t / 10 : t - 1;
          if (p != DPS_PRIO_MIN) p = p - 1;
          times[cur] = t;
          prios[cur] = p;
        end
        r.ran_id = ids[cur];
        r.time_left = t;
        r.priority_now = p;
        if (t == 0) begin
          for (int unsigned k = cur; k + 1 < count; k++) begin
            ids[k] = ids[k + 1];
            prios[k] = prios[k + 1];
            times[k] = times[k + 1];
          end
          count--;
          cur = 0;
          r.status = ST_FINISHED;
          n_done++;
        end else begin
          r.status = ST_RAN;
          if (p <= prios[0]) begin
            best = 0;
            for (int unsigned k = 1; k < count; k++)
              if (prios[k] > prios[best]) best = k;
            cur = best;
          end
        end
      end
      if (count > 0) begin
        r.next_id = ids[cur];
        r.next_valid = 1'b1;
      end
      pending_reports.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(dps_out_t got);
      dps_out_t want;
      if (pending_reports.size() == 0) begin
        $error("unexpected report word %h", got);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("ran_id", want.ran_id, got.ran_id);
      compare_field("time_left", want.time_left, got.time_left);
      compare_field("priority_now", want.priority_now, got.priority_now);
      compare_field("next_id", want.next_id, got.next_id);
      compare_field("next_valid", want.next_valid, got.next_valid);
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  dps_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  dps_out_t out_data;

  sched_table_check tracker;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycles;

  dynamic_priority_scheduler_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_report(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(dps_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_word(w);
    @(negedge clk);
  endtask

  task automatic add_proc(logic [7:0] id, logic [3:0] prio, logic [9:0] need);
    dps_in_t w;
    w.func = OP_ADD;
    w.proc_id = id;
    w.start_priority = prio;
    w.time_need = need;
    send_word(w);
  endtask

  task automatic tick_once();
    dps_in_t w;
    w = dps_in_t'($urandom);
    w.func = OP_TICK;
    send_word(w);
  endtask

  // hold off the sender until every report is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending_reports.size() != 0);
  endtask

  function automatic dps_in_t random_word(int unsigned add_pct);
    dps_in_t w;
    w.func = ($urandom_range(99) < add_pct) ? OP_ADD : OP_TICK;
    w.proc_id = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    w.start_priority = 4'($urandom);
    case ($urandom_range(19))
      0:       w.time_need = 10'd0;
      1:       w.time_need = 10'd1023;
      2, 3:    w.time_need = 10'($urandom);
      4, 5:    w.time_need = 10'($urandom_range(120, 11));
      default: w.time_need = 10'($urandom_range(12, 1));
    endcase
    return w;
  endfunction

  task automatic random_phase(int unsigned idle, int unsigned stall);
    int unsigned add_pct;
    idle_pct = idle;
    stall_pct = stall;
    add_pct = 50;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       add_pct = 80;
          1:       add_pct = 50;
          default: add_pct = 25;
        endcase
      end
      send_word(random_word(add_pct));
    end
    drain();
  endtask

  initial begin
    tracker = new;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tick_once();
    add_proc(8'd0, 4'd0, 10'd1);
    add_proc(8'd255, 4'd15, 10'd1023);
    add_proc(8'd255, 4'd15, 10'd0);
    add_proc(8'd7, 4'd8, 10'd10);
    add_proc(8'd8, 4'd8, 10'd11);
    repeat (5) tick_once();
    while (tracker.count < DPS_MAX_PROCS)
      add_proc(8'($urandom), 4'($urandom), 10'($urandom_range(3, 1)));
    add_proc(8'hAA, 4'hF, 10'h3FF);
    add_proc(8'h55, 4'h0, 10'h001);
    repeat (2) tick_once();
    drain();

    random_phase(0, 0);
    random_phase(83, 0);
    random_phase(0, 83);
    random_phase(21, 21);

    idle_pct = 0;
    stall_pct = 0;
    while (tracker.pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d adds (%0d rejected on a full table) and %0d ticks",
             tracker.n_add, tracker.n_full, tracker.n_tick);
    $display("  %0d processes finished, %0d ticks on an empty table",
             tracker.n_done, tracker.n_empty);
    if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dps_pkg.sv
rtl/core/dps_front.sv
rtl/core/dps_fifo.sv
rtl/core/dps_back.sv
rtl/core/dynamic_priority_scheduler_top.sv
bench/dynamic_priority_scheduler_top_tb.sv
